/* sv/fcca_pkg.sv */
// types, constants and control store of the fat cluster chain allocator
package fcca_pkg;

  localparam int CLUSTERS = 128;
  localparam int CL_AW    = $clog2(CLUSTERS);
  localparam int ENT_W    = 8;
  localparam int ACC_W    = ENT_W + 1;
  localparam int PC_W     = 5;

  localparam logic [ENT_W-1:0] ENT_FREE  = 8'd0;
  localparam logic [ENT_W-1:0] ENT_BAD   = 8'd247;
  localparam logic [ENT_W-1:0] ENT_EOC   = 8'd255;
  localparam logic [ENT_W-1:0] BAD_PHASE = 8'd2;
  localparam logic [ENT_W-1:0] CL_LIMIT  = ENT_W'(CLUSTERS);
  localparam logic [ENT_W-1:0] CL_LAST   = ENT_W'(CLUSTERS - 1);

  localparam logic [1:0] ACT_FORMAT   = 2'd0;
  localparam logic [1:0] ACT_ALLOCATE = 2'd1;
  localparam logic [1:0] ACT_FREE     = 2'd2;
  localparam logic [1:0] ACT_TRUNCATE = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] head_cluster;
    logic [6:0] length;
    logic [6:0] old_length;
    logic [7:0] defect_count;
  } fcca_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] first_cluster;
  } fcca_out_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DONE,
    OP_F_INIT,
    OP_F_DIV,
    OP_F_WRITE,
    OP_A_INIT,
    OP_RD,
    OP_A_LINK,
    OP_A_EOC,
    OP_NOSPACE,
    OP_W_INIT,
    OP_REL_WRITE,
    OP_T_STEP,
    OP_REJECT
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT_IN,
    C_WAIT_OUT,
    C_DEF_ZERO,
    C_ACC_LE,
    C_I_NOT_LAST,
    C_SHORT,
    C_NOT_LINK_LAST,
    C_REL_EXIT,
    C_REL_CONT,
    C_REJECT,
    C_T_CONT,
    C_RD_NEXT
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control store addresses
  localparam logic [PC_W-1:0] U_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] U_DONE      = 5'd1;
  localparam logic [PC_W-1:0] U_FMT       = 5'd2;
  localparam logic [PC_W-1:0] U_FMT_DIV   = 5'd3;
  localparam logic [PC_W-1:0] U_FMT_SWEEP = 5'd4;
  localparam logic [PC_W-1:0] U_FMT_END   = 5'd5;
  localparam logic [PC_W-1:0] U_ALC       = 5'd6;
  localparam logic [PC_W-1:0] U_ALC_RD    = 5'd7;
  localparam logic [PC_W-1:0] U_ALC_LINK  = 5'd8;
  localparam logic [PC_W-1:0] U_ALC_EOC   = 5'd9;
  localparam logic [PC_W-1:0] U_ALC_FAIL  = 5'd10;
  localparam logic [PC_W-1:0] U_FREE      = 5'd11;
  localparam logic [PC_W-1:0] U_REL_RD    = 5'd12;
  localparam logic [PC_W-1:0] U_REL_WR    = 5'd13;
  localparam logic [PC_W-1:0] U_REL_END   = 5'd14;
  localparam logic [PC_W-1:0] U_TRN       = 5'd15;
  localparam logic [PC_W-1:0] U_TRN_RD    = 5'd16;
  localparam logic [PC_W-1:0] U_TRN_STEP  = 5'd17;
  localparam logic [PC_W-1:0] U_TRN_CUT   = 5'd18;
  localparam logic [PC_W-1:0] U_TRN_END   = 5'd19;
  localparam logic [PC_W-1:0] U_TRN_REJ   = 5'd20;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: U_IDLE};
    case (addr)
      U_IDLE:      w = '{op: OP_ACCEPT,    cond: C_WAIT_IN,       target: U_IDLE};
      U_DONE:      w = '{op: OP_DONE,      cond: C_WAIT_OUT,      target: U_IDLE};
      // format: work out the bad stride, then sweep the whole table
      U_FMT:       w = '{op: OP_F_INIT,    cond: C_DEF_ZERO,      target: U_FMT_SWEEP};
      U_FMT_DIV:   w = '{op: OP_F_DIV,     cond: C_ACC_LE,        target: U_FMT_DIV};
      U_FMT_SWEEP: w = '{op: OP_F_WRITE,   cond: C_I_NOT_LAST,    target: U_FMT_SWEEP};
      U_FMT_END:   w = '{op: OP_NOP,       cond: C_ALWAYS,        target: U_DONE};
      // allocate: scan upwards, linking free entries
      U_ALC:       w = '{op: OP_A_INIT,    cond: C_SHORT,         target: U_ALC_FAIL};
      U_ALC_RD:    w = '{op: OP_RD,        cond: C_NEVER,         target: U_IDLE};
      U_ALC_LINK:  w = '{op: OP_A_LINK,    cond: C_NOT_LINK_LAST, target: U_ALC_RD};
      U_ALC_EOC:   w = '{op: OP_A_EOC,     cond: C_ALWAYS,        target: U_DONE};
      U_ALC_FAIL:  w = '{op: OP_NOSPACE,   cond: C_ALWAYS,        target: U_DONE};
      // free: walk the chain clearing entries
      U_FREE:      w = '{op: OP_W_INIT,    cond: C_NEVER,         target: U_IDLE};
      U_REL_RD:    w = '{op: OP_RD,        cond: C_REL_EXIT,      target: U_DONE};
      U_REL_WR:    w = '{op: OP_REL_WRITE, cond: C_REL_CONT,      target: U_REL_RD};
      U_REL_END:   w = '{op: OP_NOP,       cond: C_ALWAYS,        target: U_DONE};
      // truncate: walk to the new last cluster, cut, then free the tail
      U_TRN:       w = '{op: OP_W_INIT,    cond: C_REJECT,        target: U_TRN_REJ};
      U_TRN_RD:    w = '{op: OP_RD,        cond: C_REL_EXIT,      target: U_DONE};
      U_TRN_STEP:  w = '{op: OP_T_STEP,    cond: C_T_CONT,        target: U_TRN_RD};
      U_TRN_CUT:   w = '{op: OP_NOP,       cond: C_RD_NEXT,       target: U_REL_RD};
      U_TRN_END:   w = '{op: OP_NOP,       cond: C_ALWAYS,        target: U_DONE};
      U_TRN_REJ:   w = '{op: OP_REJECT,    cond: C_ALWAYS,        target: U_DONE};
      default:     w = '{op: OP_NOP,       cond: C_ALWAYS,        target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* sv/fat_cluster_chain_allocator_core.sv */
// fat cluster chain allocator: microcoded sequencer, table memory and result register
//
//   channel | signals                          | direction | payload
//   --------+----------------------------------+-----------+------------------------------
//   in      | in_valid_i  in_ready_o           | into core | in_data_i  (fcca_in_t)
//   out     | out_valid_o out_ready_i          | from core | out_data_o (fcca_out_t)
//
// one transfer in flight at a time; a format works out the bad stride (skipped with no defects)
// and then sweeps the whole table, an allocate scans upwards up to the last cluster taken,
// a free and a truncate walk the chain entry by entry, and a refusal only sets its status
// each loop step is a read word and then a word that uses it, as the next address comes from a registered table read
// reset clears the control state and the per-entry valid bits, so the table reads free at once
// a result waiting in the output register blocks only the next result load, not the next input
module fat_cluster_chain_allocator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fcca_pkg::fcca_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fcca_pkg::fcca_out_t out_data_o
);
  import fcca_pkg::*;

  // sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;

  // latched input item and result under construction
  fcca_in_t        item_q;
  logic [1:0]      status_q, status_d;
  logic [6:0]      first_q, first_d;

  // datapath registers
  logic [ENT_W-1:0] idx_q, idx_d;     // table pointer, may hold any entry value
  logic [ENT_W-1:0] cnt_q, cnt_d;     // link count or walk step count
  logic [ACC_W-1:0] acc_q, acc_d;     // stride accumulator for format
  logic [ENT_W-1:0] k_q, k_d;         // bad stride
  logic [ENT_W-1:0] ph_q, ph_d;       // index modulo stride
  logic [CL_AW-1:0] prev_q, prev_d;   // last cluster linked
  logic [CL_AW-1:0] head_q, head_d;   // head of the new chain
  logic [ENT_W-1:0] free_q, free_d;   // number of free entries

  // table memory, per-entry valid bits stand in for the reset clear
  logic [ENT_W-1:0]    mem_q [CLUSTERS];
  logic [CLUSTERS-1:0] vld_q;
  logic [ENT_W-1:0]    rd_q;
  logic                rd_vld_q;
  logic                mem_we;
  logic [CL_AW-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic                mem_re;

  // output register
  fcca_out_t out_q;
  logic      out_valid_q;

  // decoded values
  logic [ENT_W-1:0] rd_val;
  logic             rd_free, rd_stop, rd_eoc;
  logic [ENT_W-1:0] len_ext, old_ext, need;
  logic [ACC_W-1:0] def_ext;
  logic             is_bad;
  logic             acc_le;
  logic             out_free;
  logic             in_fire;
  logic             cond_hit;
  logic [PC_W-1:0]  entry_pc;

  assign uw = ucode_rom(pc_q);

  assign rd_val  = rd_vld_q ? rd_q : ENT_FREE;
  assign rd_free = (rd_val == ENT_FREE);
  assign rd_stop = rd_free || (rd_val == ENT_BAD);
  assign rd_eoc  = (rd_val == ENT_EOC);

  assign len_ext = ENT_W'(item_q.length);
  assign old_ext = ENT_W'(item_q.old_length);
  assign need    = len_ext + ENT_W'(1);
  assign def_ext = ACC_W'(item_q.defect_count);
  assign acc_le  = (acc_q <= ACC_W'(CLUSTERS));
  // i mod stride == 2, with no marks when the stride came out as zero
  assign is_bad  = (k_q != '0) && (ph_q == BAD_PHASE);

  assign in_ready_o = (uw.op == OP_ACCEPT);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    case (in_data_i.action)
      ACT_FORMAT:   entry_pc = U_FMT;
      ACT_ALLOCATE: entry_pc = U_ALC;
      ACT_FREE:     entry_pc = U_FREE;
      ACT_TRUNCATE: entry_pc = U_TRN;
      default:      entry_pc = U_IDLE;
    endcase
  end

  // jump conditions
  always_comb begin
    case (uw.cond)
      C_DEF_ZERO:      cond_hit = (item_q.defect_count == '0);
      C_ACC_LE:        cond_hit = acc_le;
      C_I_NOT_LAST:    cond_hit = (idx_q != CL_LAST);
      C_SHORT:         cond_hit = (free_q < need);
      C_NOT_LINK_LAST: cond_hit = !(rd_free && (cnt_q == len_ext));
      C_REL_EXIT:      cond_hit = (idx_q >= CL_LIMIT) || (cnt_q == CL_LIMIT);
      C_REL_CONT:      cond_hit = !rd_stop && !rd_eoc;
      C_REJECT:        cond_hit = (len_ext >= old_ext);
      C_T_CONT:        cond_hit = !rd_stop && !rd_eoc && (cnt_q != len_ext);
      C_RD_NEXT:       cond_hit = !rd_stop && !rd_eoc;
      default:         cond_hit = 1'b0;
    endcase
  end

  // next step address
  always_comb begin
    case (uw.cond)
      C_NEVER:    pc_d = pc_q + PC_W'(1);
      C_ALWAYS:   pc_d = uw.target;
      C_WAIT_IN:  pc_d = in_valid_i ? entry_pc : pc_q;
      C_WAIT_OUT: pc_d = out_free ? uw.target : pc_q;
      default:    pc_d = cond_hit ? uw.target : pc_q + PC_W'(1);
    endcase
  end

  // datapath, one operation per control word
  always_comb begin
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    k_d       = k_q;
    ph_d      = ph_q;
    prev_d    = prev_q;
    head_d    = head_q;
    free_d    = free_q;
    status_d  = status_q;
    first_d   = first_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q[CL_AW-1:0];
    mem_wdata = ENT_FREE;
    mem_re    = 1'b0;
    case (uw.op)
      OP_ACCEPT: begin
        status_d = ST_DONE;
        first_d  = '0;
      end
      OP_F_INIT: begin
        idx_d  = '0;
        acc_d  = def_ext;
        k_d    = '0;
        ph_d   = '0;
        free_d = CL_LIMIT;
      end
      OP_F_DIV: begin
        // stride = CLUSTERS / defect_count by repeated addition
        if (acc_le) begin
          k_d   = k_q + ENT_W'(1);
          acc_d = acc_q + def_ext;
        end
      end
      OP_F_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = is_bad ? ENT_BAD : ENT_FREE;
        if (is_bad) free_d = free_q - ENT_W'(1);
        idx_d     = idx_q + ENT_W'(1);
        ph_d      = (ph_q == k_q - ENT_W'(1)) ? '0 : ph_q + ENT_W'(1);
      end
      OP_A_INIT: begin
        idx_d = '0;
        cnt_d = '0;
      end
      OP_RD: begin
        mem_re = 1'b1;
      end
      OP_A_LINK: begin
        if (rd_free) begin
          if (cnt_q != '0) begin
            mem_we    = 1'b1;
            mem_waddr = prev_q;
            mem_wdata = idx_q;
          end else begin
            head_d = idx_q[CL_AW-1:0];
          end
          prev_d = idx_q[CL_AW-1:0];
          cnt_d  = cnt_q + ENT_W'(1);
          free_d = free_q - ENT_W'(1);
        end
        idx_d = idx_q + ENT_W'(1);
      end
      OP_A_EOC: begin
        mem_we    = 1'b1;
        mem_waddr = prev_q;
        mem_wdata = ENT_EOC;
        first_d   = 7'(head_q);
      end
      OP_NOSPACE: begin
        status_d = ST_NOSPACE;
      end
      OP_W_INIT: begin
        idx_d = ENT_W'(item_q.head_cluster);
        cnt_d = '0;
      end
      OP_REL_WRITE: begin
        if (!rd_stop) begin
          mem_we    = 1'b1;
          mem_wdata = ENT_FREE;
          free_d    = free_q + ENT_W'(1);
          idx_d     = rd_val;
          cnt_d     = cnt_q + ENT_W'(1);
        end
      end
      OP_T_STEP: begin
        if (!rd_stop) begin
          idx_d = rd_val;
          if (cnt_q == len_ext) begin
            // new last cluster, the tail walk restarts its step count
            mem_we    = 1'b1;
            mem_wdata = ENT_EOC;
            cnt_d     = '0;
          end else begin
            cnt_d = cnt_q + ENT_W'(1);
          end
        end
      end
      OP_REJECT: begin
        status_d = ST_REJECT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= U_IDLE;
      free_q      <= CL_LIMIT;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      free_q <= free_d;
      if (mem_we) vld_q[mem_waddr] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[idx_q[CL_AW-1:0]];
      if (uw.op == OP_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_data_i;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    k_q      <= k_d;
    ph_q     <= ph_d;
    prev_q   <= prev_d;
    head_q   <= head_d;
    status_q <= status_d;
    first_q  <= first_d;
    if (uw.op == OP_DONE && out_free) begin
      out_q.status        <= status_q;
      out_q.first_cluster <= first_q;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[idx_q[CL_AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // free count can never pass the table size
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CL_LIMIT)
    else $error("free cluster count above table size");

  // a result is loaded only from the completion step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q) == U_DONE)
    else $error("result loaded outside the completion step");

  // an accepted transfer always leaves the idle word
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> pc_q != U_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  // the table is never written while waiting for work
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (pc_q != U_IDLE) && (pc_q != U_DONE))
    else $error("table written while idle");

endmodule
